// File: rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon test.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam int COORD_W     = 16;
  localparam int TOL_W       = 8;
  localparam int QUEUE_DEPTH = 4;

  // Edge arithmetic widths: coordinate differences, their products, product difference.
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CMP_W  = PROD_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic                      last_vertex;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic status;
  } out_item_t;

  // One vertex as handed from the front to the edge-test pipeline.
  typedef struct packed {
    logic                      first;
    logic                      last;
    logic                      short_poly;
    logic                      outside;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [COORD_W-1:0] prev_x;
    logic signed [COORD_W-1:0] prev_y;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/point_in_polygon_test.sv
// Top level of the streaming point-in-polygon test.
`timescale 1ns / 1ps
`default_nettype none

// Point-in-polygon test by crossing number. Send a polygon as a run of vertex items,
// one per cycle if desired while vertex_stall is low, with the query point on the
// first vertex and last_vertex set on the final one; exactly one result item follows
// each last vertex, with status 1 when the polygon had fewer than three vertices. A
// point on a near-horizontal edge (within edge_tolerance in y) counts as inside. The
// block sustains one vertex per cycle while results are not stalled. A result passes
// through a four-item queue, the two-register edge-test pipeline (differences, then
// two products per edge) and the result register. The queue separates vertex intake
// from the edge pipeline, so a stalled result holds off intake only once it is full.
// Write edge_tolerance through cfg_we/cfg_data only while no polygon is in flight.

module point_in_polygon_test (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      vertex_valid,
  output logic                      vertex_stall,
  input  pip_pkg::in_item_t         vertex,
  output logic                      result_valid,
  input  logic                      result_stall,
  output pip_pkg::out_item_t        result,
  input  logic                      cfg_we,
  input  logic [pip_pkg::TOL_W-1:0] cfg_data
);

  logic [pip_pkg::TOL_W-1:0] edge_tolerance;
  logic                      take;
  logic                      q_full, q_valid, q_pop;
  pip_pkg::job_t             job_in, job_out;

  assign vertex_stall = q_full;
  assign take         = vertex_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_tolerance <= '0;
    end else if (cfg_we) begin
      edge_tolerance <= cfg_data;
    end
  end

  pip_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (vertex),
    .job  (job_in)
  );

  pip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (job_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (job_out)
  );

  pip_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tol          (edge_tolerance),
    .job_valid    (q_valid),
    .job          (job_out),
    .job_pop      (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: rtl/pip_front.sv
// Front end: polygon bookkeeping, bounding box and job forming per vertex.
`timescale 1ns / 1ps
`default_nettype none

module pip_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  pip_pkg::in_item_t item,
  output pip_pkg::job_t     job
);

  logic [1:0]                         count;
  logic [1:0]                         count_next;
  logic signed [pip_pkg::COORD_W-1:0] held_qx, held_qy;
  logic signed [pip_pkg::COORD_W-1:0] first_x, first_y;
  logic signed [pip_pkg::COORD_W-1:0] prev_x, prev_y;
  logic signed [pip_pkg::COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic signed [pip_pkg::COORD_W-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
  logic signed [pip_pkg::COORD_W-1:0] min_x_use, max_x_use, min_y_use, max_y_use;
  logic signed [pip_pkg::COORD_W-1:0] qx, qy, fx, fy, vx, vy;
  logic                               start;

  assign vx    = item.vertex_x;
  assign vy    = item.vertex_y;
  assign start = (count == 2'd0);

  always_comb begin
    qx        = start ? item.query_x : held_qx;
    qy        = start ? item.query_y : held_qy;
    fx        = start ? vx : first_x;
    fy        = start ? vy : first_y;
    min_x_use = start ? vx : min_x;
    max_x_use = start ? vx : max_x;
    min_y_use = start ? vy : min_y;
    max_y_use = start ? vy : max_y;

    min_x_next = (vx < min_x_use) ? vx : min_x_use;
    max_x_next = (vx > max_x_use) ? vx : max_x_use;
    min_y_next = (vy < min_y_use) ? vy : min_y_use;
    max_y_next = (vy > max_y_use) ? vy : max_y_use;

    if (item.last_vertex) begin
      count_next = 2'd0;
    end else if (count == 2'd3) begin
      count_next = count;
    end else begin
      count_next = count + 2'd1;
    end

    job.first      = start;
    job.last       = item.last_vertex;
    job.short_poly = (count < 2'd2);
    // Compare against both old box and this vertex: same as comparing with the grown box.
    job.outside    = (qx < min_x_use && qx < vx) || (qx > max_x_use && qx > vx) ||
                     (qy < min_y_use && qy < vy) || (qy > max_y_use && qy > vy);
    job.cur_x      = vx;
    job.cur_y      = vy;
    job.prev_x     = prev_x;
    job.prev_y     = prev_y;
    job.first_x    = fx;
    job.first_y    = fy;
    job.px         = qx;
    job.py         = qy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (take) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_qx <= qx;
      held_qy <= qy;
      first_x <= fx;
      first_y <= fy;
      prev_x  <= vx;
      prev_y  <= vy;
      min_x   <= min_x_next;
      max_x   <= max_x_next;
      min_y   <= min_y_next;
      max_y   <= max_y_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pip_queue.sv
// Short job queue between the front end and the edge-test pipeline.
`timescale 1ns / 1ps
`default_nettype none

module pip_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pip_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output pip_pkg::job_t pop_data
);

  localparam int PTR_W = $clog2(pip_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  pip_pkg::job_t    slots [pip_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(pip_pkg::QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pip_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pip_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pip_back.sv
// Back end: pipelined edge tests, crossing parity, on-edge flag and result register.
`timescale 1ns / 1ps
`default_nettype none

module pip_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [pip_pkg::TOL_W-1:0] tol,
  input  logic                      job_valid,
  input  pip_pkg::job_t             job,
  output logic                      job_pop,
  output logic                      result_valid,
  input  logic                      result_stall,
  output pip_pkg::out_item_t        result
);

  localparam int CW = pip_pkg::COORD_W;
  localparam int DW = pip_pkg::DIFF_W;
  localparam int PW = pip_pkg::PROD_W;
  localparam int KW = pip_pkg::CMP_W;

  typedef struct packed {
    logic signed [DW-1:0] ma;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] mc;
    logic signed [DW-1:0] md;
    logic                 straddle;
    logic                 d_pos;
    logic                 near_hit;
  } edge_prep_t;

  typedef struct packed {
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    logic                 straddle;
    logic                 d_pos;
    logic                 near_hit;
  } edge_prod_t;

  typedef struct packed {
    logic first;
    logic last;
    logic short_poly;
    logic outside;
  } ctrl_t;

  function automatic logic near_y(logic signed [CW-1:0] y, logic signed [CW-1:0] py,
                                  logic [pip_pkg::TOL_W-1:0] t);
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        m;
    dy = DW'(y) - DW'(py);
    m  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    return m <= DW'(t);
  endfunction

  function automatic edge_prep_t prep(logic signed [CW-1:0] xi, logic signed [CW-1:0] yi,
                                      logic signed [CW-1:0] xj, logic signed [CW-1:0] yj,
                                      logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                      logic en, logic [pip_pkg::TOL_W-1:0] t);
    edge_prep_t e;
    e.d        = DW'(yj) - DW'(yi);
    e.ma       = DW'(px) - DW'(xi);
    e.mc       = DW'(xj) - DW'(xi);
    e.md       = DW'(py) - DW'(yi);
    e.straddle = en && ((yi > py) != (yj > py));
    e.d_pos    = (yj > yi);
    e.near_hit = en && near_y(yi, py, t) && near_y(yj, py, t) && ((xi > px) != (xj > px));
    return e;
  endfunction

  // Sign of (px-xi)*d - (xj-xi)*(py-yi), read against the direction of the edge.
  function automatic logic crosses(edge_prod_t e);
    logic signed [KW-1:0] diff;
    logic                 lt, gt;
    diff = KW'(e.p) - KW'(e.q);
    lt   = diff[KW-1];
    gt   = !lt && (diff != '0);
    return e.straddle && (e.d_pos ? lt : gt);
  endfunction

  logic       adv;
  logic       s1_valid, s2_valid;
  ctrl_t      s1_ctrl, s2_ctrl;
  edge_prep_t s1_a, s1_b;
  edge_prod_t s2_a, s2_b;
  logic       parity, hit;
  logic       cross_a, cross_b, hit_a, hit_b, parity_next, hit_next;

  // Whole pipeline moves together; it only waits on a stalled result.
  assign adv     = !result_valid || !result_stall;
  assign job_pop = adv && job_valid;

  always_comb begin
    cross_a     = crosses(s2_a);
    cross_b     = crosses(s2_b);
    hit_a       = !cross_a && s2_a.near_hit;
    hit_b       = !cross_b && s2_b.near_hit;
    parity_next = (s2_ctrl.first ? 1'b0 : parity) ^ cross_a ^ cross_b;
    hit_next    = (s2_ctrl.first ? 1'b0 : hit) | hit_a | hit_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      parity       <= 1'b0;
      hit          <= 1'b0;
    end else if (adv) begin
      s1_valid     <= job_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid && s2_ctrl.last;
      if (s2_valid) begin
        parity <= parity_next;
        hit    <= hit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctrl.first      <= job.first;
      s1_ctrl.last       <= job.last;
      s1_ctrl.short_poly <= job.short_poly;
      s1_ctrl.outside    <= job.outside;
      // Edge from this vertex back to the previous one, then the closing edge.
      s1_a <= prep(job.cur_x, job.cur_y, job.prev_x, job.prev_y, job.px, job.py,
                   !job.first, tol);
      s1_b <= prep(job.first_x, job.first_y, job.cur_x, job.cur_y, job.px, job.py,
                   job.last, tol);

      s2_ctrl       <= s1_ctrl;
      s2_a.p        <= s1_a.ma * s1_a.d;
      s2_a.q        <= s1_a.mc * s1_a.md;
      s2_a.straddle <= s1_a.straddle;
      s2_a.d_pos    <= s1_a.d_pos;
      s2_a.near_hit <= s1_a.near_hit;
      s2_b.p        <= s1_b.ma * s1_b.d;
      s2_b.q        <= s1_b.mc * s1_b.md;
      s2_b.straddle <= s1_b.straddle;
      s2_b.d_pos    <= s1_b.d_pos;
      s2_b.near_hit <= s1_b.near_hit;

      result.status     <= s2_ctrl.short_poly;
      result.inside_res <= !s2_ctrl.short_poly && !s2_ctrl.outside &&
                           (hit_next || parity_next);
    end
  end

endmodule

`default_nettype wire

// File: rtl/pip_checker.sv
// Port-level checks for the point-in-polygon test, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pip_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      vertex_valid,
  input logic                      vertex_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input pip_pkg::out_item_t        result
);

  // A stalled result item stays put.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result item changed or dropped");

  // A short polygon never reports inside.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.status && result.inside_res))
    else $error("short polygon reported inside");

  // Reset empties the pipeline and the queue.
  assert property (@(posedge clk) rst |=> !result_valid && !vertex_stall)
    else $error("state not cleared by reset");

  // Intake only backs up once results have been held off.
  assert property (@(posedge clk) disable iff (rst)
    vertex_valid && vertex_stall |-> $past(result_valid && result_stall))
    else $error("vertex stalled without a held result");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk          (clk),
  .rst          (rst),
  .vertex_valid (vertex_valid),
  .vertex_stall (vertex_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
